[hw/rtl/bitmap_first_free_allocator_defines.svh]
// assertion macros used by the checker file
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BMFF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmff same-cycle check failed");

// next-cycle implication, off while reset is high
`define BMFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmff next-cycle check failed");

`endif

[hw/rtl/bmff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmff_pkg
// Shared constants and types of the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bmff_pkg;

  localparam int MAP_BITS_DEF = 1024;
  localparam int INDEX_SPAN   = 1024;
  localparam int INDEX_W      = 10;
  localparam int LIMIT_W      = 11;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // one set bit, moved to the lane being changed
  localparam logic [WORD_W-1:0] BIT_ONE = 32'h1;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } zero_find_t;

endpackage

[hw/rtl/bmff_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bmff_zero_find.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmff_zero_find
// Finds the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bmff_zero_find (
  input  logic [bmff_pkg::WORD_W-1:0] word,
  output bmff_pkg::zero_find_t        res
);

  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    // walk down so the lowest clear lane wins
    for (int i = bmff_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = bmff_pkg::BIT_W'(i);
      end
    end
  end

endmodule

[hw/rtl/bitmap_first_free_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over a bitmap of used entries, scanned a word at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries mode and free_index; a word is
// taken at an edge with in_valid high and in_stall low. Output channel
// (out_valid / out_stall) carries granted_index and status, one word per input.
// cfg_wr_en / cfg_wr_data write entry_limit; write it only while idle.
// The map sits in a RAM of 32-bit words with one registered read port. An
// allocate reads word 0 in the accept cycle and checks one word per cycle in
// the zero-find unit while fetching the next, in S_SCAN; the result then goes
// through S_PUSH into the output register. A free reads its word on accept,
// clears the bit in S_FREE, then passes through S_PUSH.
// Only one word is worked on at a time; in_stall is high from accept until
// the result is loaded into the output register, so a new word can be taken
// while an earlier result is still stalled at the output.
// After reset a clearing pass writes zero to every map word, one per cycle;
// in_stall stays high during it.
// A stalled result holds in the output register; the block waits for it only
// when a newer result is ready to replace it.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
  parameter int MAP_BITS = bmff_pkg::MAP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [bmff_pkg::INDEX_W-1:0]  free_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmff_pkg::INDEX_W-1:0]  granted_index,
  output logic                          status,
  input  logic                          cfg_wr_en,
  input  logic [bmff_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  localparam int LW        = bmff_pkg::LIMIT_W;
  localparam int IW        = bmff_pkg::INDEX_W;
  localparam int WW        = bmff_pkg::WORD_W;
  localparam int BW        = bmff_pkg::BIT_W;
  localparam int USED_BITS = (MAP_BITS < bmff_pkg::INDEX_SPAN) ? MAP_BITS
                                                               : bmff_pkg::INDEX_SPAN;
  localparam int WORDS     = (USED_BITS + WW - 1) / WW;
  localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [LW-1:0]      USED_LIM  = LW'(USED_BITS);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_PUSH
  } state_t;

  state_t               state;
  logic [LW-1:0]        entry_limit;
  logic [WORD_AW-1:0]   word_ptr;
  logic [IW-1:0]        fidx;
  logic [IW-1:0]        res_index;
  logic                 res_status;

  logic [LW-1:0]        lim;
  logic [LW-1:0]        base;
  logic [LW-1:0]        next_base;
  logic [LW-1:0]        cand;
  logic                 hit;
  logic                 go_on;
  logic                 free_ok;
  logic [WORD_AW-1:0]   fword;
  logic [WORD_AW-1:0]   raddr;
  logic [WORD_AW-1:0]   waddr;
  logic                 we;
  logic [WW-1:0]        wdata;
  logic [WW-1:0]        rdata;
  bmff_pkg::zero_find_t zf;

  bmff_ram #(
    .WIDTH (WW),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bmff_zero_find u_find (
    .word (rdata),
    .res  (zf)
  );

  assign in_stall  = (state != S_IDLE);
  assign lim       = (entry_limit < USED_LIM) ? entry_limit : USED_LIM;
  assign base      = LW'(word_ptr) << BW;
  assign next_base = base + LW'(WW);
  assign cand      = base + LW'(zf.pos);
  assign hit       = zf.found && (cand < lim);
  // no clear bit here and the next word still starts below the limit
  assign go_on     = !zf.found && (next_base < lim);
  assign fword     = WORD_AW'(fidx >> BW);
  assign free_ok   = ({1'b0, fidx} < USED_LIM);

  always_comb begin
    raddr = word_ptr;
    waddr = word_ptr;
    we    = 1'b0;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        raddr = (mode == bmff_pkg::MODE_FREE) ? WORD_AW'(free_index >> BW) : '0;
      end
      S_SCAN: begin
        raddr = word_ptr + 1'b1;
        we    = hit;
        wdata = rdata | (bmff_pkg::BIT_ONE << zf.pos);
      end
      S_FREE: begin
        waddr = fword;
        we    = free_ok;
        wdata = rdata & ~(bmff_pkg::BIT_ONE << fidx[BW-1:0]);
      end
      S_PUSH: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      word_ptr    <= '0;
      entry_limit <= bmff_pkg::LIMIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_limit <= cfg_wr_data;
      end
      // in S_PUSH the output register is handled below
      if (out_valid && !out_stall && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (word_ptr == LAST_WORD) begin
            word_ptr <= '0;
            state    <= S_IDLE;
          end else begin
            word_ptr <= word_ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (mode == bmff_pkg::MODE_FREE) begin
              fidx  <= free_index;
              state <= S_FREE;
            end else begin
              word_ptr <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_index  <= cand[IW-1:0];
            res_status <= bmff_pkg::STATUS_DONE;
            state      <= S_PUSH;
          end else if (go_on) begin
            word_ptr <= word_ptr + 1'b1;
          end else begin
            res_index  <= '0;
            res_status <= bmff_pkg::STATUS_NO_SPACE;
            state      <= S_PUSH;
          end
        end
        S_FREE: begin
          res_index  <= '0;
          res_status <= bmff_pkg::STATUS_DONE;
          state      <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            granted_index <= res_index;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/bmff_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmff_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_defines.svh"

module bmff_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bmff_pkg::INDEX_W-1:0] granted_index,
  input logic                         status
);

  logic out_held;
  logic no_space_out;

  assign out_held     = out_valid && out_stall;
  assign no_space_out = out_valid && (status == bmff_pkg::STATUS_NO_SPACE);

  // a stalled result word holds
  `BMFF_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable({granted_index, status}))

  // a failed allocate never carries an index
  `BMFF_ASSERT_NOW(a_nospace_zero, clk, rst, no_space_out, granted_index == '0)

  // one word in flight: an accept is always followed by a busy cycle
  `BMFF_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind bitmap_first_free_allocator bmff_checker u_bmff_checker (.*);

[sim/tb_bitmap_first_free_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_free_allocator
// Self-checking bench for the first-free bitmap allocator. A shadow bitmap and
// limit register predict every grant and status. Directed words cover reset
// defaults and the limit extremes. Then come a long output hold-off, a fill of
// the whole map, random allocate/free mixes under several limits, and a tail
// with no idling. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_bitmap_first_free_allocator;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    logic [bmff_pkg::INDEX_W-1:0] index;
    logic                         status;
  } grant_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         mode;
  logic [bmff_pkg::INDEX_W-1:0] free_index;
  logic                         out_valid;
  logic                         out_stall;
  logic [bmff_pkg::INDEX_W-1:0] granted_index;
  logic                         status;
  logic                         cfg_wr_en;
  logic [bmff_pkg::LIMIT_W-1:0] cfg_wr_data;

  // shadow of the block state
  bit                           used_bits [bmff_pkg::MAP_BITS_DEF];
  logic [bmff_pkg::LIMIT_W-1:0] limit_shadow;

  grant_t pending_grants[$];
  grant_t last_grant;
  int     mismatch_count;
  bit     tx_gaps;
  bit     rx_gaps;
  int     hold_cycles;

  bitmap_first_free_allocator #(
    .MAP_BITS(bmff_pkg::MAP_BITS_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .free_index   (free_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted_index(granted_index),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int usable_entries();
    int lim;
    lim = int'(limit_shadow);
    if (lim > bmff_pkg::MAP_BITS_DEF) lim = bmff_pkg::MAP_BITS_DEF;
    // grant index width caps the limit too
    if (lim > bmff_pkg::INDEX_SPAN) lim = bmff_pkg::INDEX_SPAN;
    return lim;
  endfunction

  function automatic grant_t predict_request(input logic m,
                                             input logic [bmff_pkg::INDEX_W-1:0] idx);
    grant_t r;
    int     lim;
    int     i;
    int     slot;
    r.index  = '0;
    r.status = bmff_pkg::STATUS_DONE;
    if (m == bmff_pkg::MODE_ALLOC) begin
      lim  = usable_entries();
      slot = -1;
      i    = 0;
      while (slot < 0 && i < lim) begin
        if (!used_bits[i]) slot = i;
        i++;
      end
      // lowest free at or past the limit leaves the map untouched
      if (slot < 0) begin
        r.status = bmff_pkg::STATUS_NO_SPACE;
      end else begin
        used_bits[slot] = 1'b1;
        r.index = bmff_pkg::INDEX_W'(slot);
      end
    end else begin
      used_bits[idx] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [bmff_pkg::INDEX_W-1:0] pick_used_below(input int bound);
    int start;
    int k;
    int pos;
    if (bound <= 0) bound = bmff_pkg::MAP_BITS_DEF;
    start = $urandom_range(0, bound - 1);
    for (k = 0; k < bound; k++) begin
      pos = (start + k) % bound;
      if (used_bits[pos]) return bmff_pkg::INDEX_W'(pos);
    end
    return bmff_pkg::INDEX_W'($urandom());
  endfunction

  // send one word, predict its result once it is taken
  task automatic issue_request(input logic m, input logic [bmff_pkg::INDEX_W-1:0] idx);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    free_index <= idx;
    do @(posedge clk); while (in_stall);
    last_grant = predict_request(m, idx);
    pending_grants.push_back(last_grant);
  endtask

  task automatic wait_all_granted();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_entry_limit(input logic [bmff_pkg::LIMIT_W-1:0] value);
    wait_all_granted();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_shadow = value;
  endtask

  task automatic shuffle_idling();
    tx_gaps = ($urandom_range(0, 3) != 0);
    rx_gaps = ($urandom_range(0, 3) != 0);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) issue_request(bmff_pkg::MODE_ALLOC, bmff_pkg::INDEX_W'($urandom()));
    else if (pick < 8) issue_request(bmff_pkg::MODE_FREE, pick_used_below(usable_entries()));
    else if (pick == 8)
      issue_request(bmff_pkg::MODE_FREE, pick_used_below(bmff_pkg::MAP_BITS_DEF));
    else issue_request(bmff_pkg::MODE_FREE, bmff_pkg::INDEX_W'($urandom()));
  endtask

  task automatic test_reset_defaults();
    // free_index is don't-care on allocate, drive extremes anyway
    issue_request(bmff_pkg::MODE_ALLOC, '1);
    issue_request(bmff_pkg::MODE_ALLOC, '0);
    issue_request(bmff_pkg::MODE_ALLOC, 10'h2aa);
    issue_request(bmff_pkg::MODE_FREE, 10'd1);
    issue_request(bmff_pkg::MODE_ALLOC, 10'h155);
    issue_request(bmff_pkg::MODE_FREE, '1);
    issue_request(bmff_pkg::MODE_FREE, '0);
    issue_request(bmff_pkg::MODE_FREE, '0);
    issue_request(bmff_pkg::MODE_ALLOC, '0);
  endtask

  task automatic test_limit_extremes();
    set_entry_limit('0);
    issue_request(bmff_pkg::MODE_ALLOC, '1);
    issue_request(bmff_pkg::MODE_FREE, 10'd2);
    // lowest free lands exactly on the limit
    set_entry_limit(11'd3);
    issue_request(bmff_pkg::MODE_ALLOC, '0);
    issue_request(bmff_pkg::MODE_ALLOC, '0);
    set_entry_limit('1);
    issue_request(bmff_pkg::MODE_ALLOC, '1);
    set_entry_limit(bmff_pkg::LIMIT_RESET);
    issue_request(bmff_pkg::MODE_ALLOC, '0);
    issue_request(bmff_pkg::MODE_FREE, 10'd3);
    issue_request(bmff_pkg::MODE_ALLOC, '1);
  endtask

  task automatic test_output_holdoff();
    wait_all_granted();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_cycles = 300;
    repeat (16) random_request();
    wait_all_granted();
  endtask

  task automatic test_fill_to_full();
    int no_space_seen;
    int guard;
    set_entry_limit(bmff_pkg::LIMIT_RESET);
    no_space_seen = 0;
    for (guard = 0; guard < 1600 && no_space_seen < 6; guard++) begin
      if (guard % 128 == 0) shuffle_idling();
      if ($urandom_range(0, 19) == 0) begin
        issue_request(bmff_pkg::MODE_FREE, pick_used_below(bmff_pkg::MAP_BITS_DEF));
      end else begin
        issue_request(bmff_pkg::MODE_ALLOC, bmff_pkg::INDEX_W'($urandom()));
        if (last_grant.status == bmff_pkg::STATUS_NO_SPACE) no_space_seen++;
      end
    end
  endtask

  task automatic test_random_mix();
    logic [bmff_pkg::LIMIT_W-1:0] limits [5];
    int n;
    limits = '{bmff_pkg::LIMIT_W'($urandom_range(1, 48)), '0, '1,
               bmff_pkg::LIMIT_W'($urandom_range(1, 1024)), 11'd1025};
    foreach (limits[p]) begin
      set_entry_limit(limits[p]);
      for (n = 0; n < 100; n++) begin
        if (n % 32 == 0) shuffle_idling();
        random_request();
      end
    end
  endtask

  task automatic test_quiet_tail();
    set_entry_limit(bmff_pkg::LIMIT_RESET);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (150) random_request();
  endtask

  initial begin : receiver
    int burst_left;
    burst_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (rx_gaps && !rst && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result word with none expected, index %0d status %0d",
                   $time, granted_index, status);
        mismatch_count++;
      end else begin
        want = pending_grants.pop_front();
        if (granted_index !== want.index) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: granted_index expected %0d got %0d",
                     $time, want.index, granted_index);
          mismatch_count++;
        end
        if (status !== want.status) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_bitmap_first_free_allocator: errors");
    $finish;
  end

  initial begin : main
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = bmff_pkg::MODE_ALLOC;
    free_index   = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    limit_shadow = bmff_pkg::LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_reset_defaults();
    test_limit_extremes();
    test_output_holdoff();
    test_fill_to_full();
    test_random_mix();
    test_quiet_tail();
    wait_all_granted();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("tb_bitmap_first_free_allocator: clean");
    end else begin
      $display("tb_bitmap_first_free_allocator: errors");
    end
    $finish;
  end

endmodule

[bitmap_first_free_allocator.f]
+incdir+hw/rtl
hw/rtl/bmff_pkg.sv
hw/rtl/bmff_ram.sv
hw/rtl/bmff_zero_find.sv
hw/rtl/bitmap_first_free_allocator.sv
hw/rtl/bmff_checker.sv
sim/tb_bitmap_first_free_allocator.sv
